[rtl/dkel_pkg.sv]
// Package for the debounced key event latch.
// Holds shared widths, register indexes, status and edge codes, reset values.
// No dependencies.
package dkel_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int TIME_BITS_DEF    = 32;

    // channels that have a window register and a base code byte
    localparam int CFG_CHANS   = 4;
    localparam int TICKS_W     = 32;
    localparam int CHAN_W      = 2;
    localparam int WINDOW_W    = 16;
    localparam int EDGE_EN_W   = 8;
    localparam int BASE_W      = 32;
    localparam int KEY_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic [1:0] status_t;
    typedef logic [1:0] pend_t;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_IGNORED = 2'd1;
    localparam status_t STATUS_EMPTY   = 2'd2;

    localparam pend_t CODE_NONE = 2'd0;
    localparam pend_t CODE_FALL = 2'd1;
    localparam pend_t CODE_RISE = 2'd2;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd5;

    localparam logic [WINDOW_W-1:0]  WINDOW_RST [CFG_CHANS] =
        '{16'd1200, 16'd1, 16'd1, 16'd1200};
    localparam logic [EDGE_EN_W-1:0] EDGE_EN_RST = 8'h7D;
    localparam logic [BASE_W-1:0]    BASE_RST    = 32'h0E08_0400;

endpackage

[rtl/dkel_if.sv]
// Channel interfaces for the debounced key event latch.
// Depends on dkel_pkg for field widths.
interface dkel_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [dkel_pkg::CHAN_W-1:0]   channel;
    logic                          pin_level;
    logic [dkel_pkg::TICKS_W-1:0]  now_ticks;

    modport source (output valid, req_type, channel, pin_level, now_ticks, input ready);
    modport sink   (input valid, req_type, channel, pin_level, now_ticks, output ready);
endinterface

interface dkel_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dkel_pkg::KEY_W-1:0]    key_code;
    dkel_pkg::status_t             status;
    logic                          any_pending;

    modport source (output valid, key_code, status, any_pending, input ready);
    modport sink   (input valid, key_code, status, any_pending, output ready);
endinterface

interface dkel_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dkel_pkg::CFG_IDX_W-1:0]   index;
    logic [dkel_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/debounced_key_event_latch_top.sv]
// Debounced key event latch: per-channel debounce, edge latching, key readout.
// Depends on dkel_pkg and the channel interfaces in dkel_if.sv.
//
//  channel | dir | carries
//  --------+-----+-------------------------------------------------
//  req     | in  | req_type, channel, pin_level, now_ticks
//  rsp     | out | key_code, status, any_pending
//  cfg     | in  | index, data (register writes, always ready)
//
// One item per cycle sustained while rsp is ready; a req transfer goes through
// the input register, then the result register, before its result is offered.
// The per-channel state is read and written in the same cycle as the result
// register loads, so consecutive items see each other's updates.
// A stalled rsp holds the result; req stays ready while the input stage can move.
// rst_n clears valid flags and channel state, loads the register reset values.
module debounced_key_event_latch_top #(
    parameter int NUM_CHANNELS = dkel_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = dkel_pkg::TIME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    dkel_req_if.sink     req,
    dkel_rsp_if.source   rsp,
    dkel_cfg_if.sink     cfg
);

    // configuration registers
    logic [dkel_pkg::WINDOW_W-1:0]  window_reg [dkel_pkg::CFG_CHANS];
    logic [dkel_pkg::EDGE_EN_W-1:0] edge_en_reg;
    logic [dkel_pkg::BASE_W-1:0]    base_reg;

    // per-channel state
    logic [TIME_BITS-1:0]    last_reg  [NUM_CHANNELS];
    logic [TIME_BITS-1:0]    last_next [NUM_CHANNELS];
    dkel_pkg::pend_t         pend_reg  [NUM_CHANNELS];
    dkel_pkg::pend_t         pend_next [NUM_CHANNELS];

    // input stage
    logic                          s1_valid_reg;
    logic                          s1_req_type_reg;
    logic [dkel_pkg::CHAN_W-1:0]   s1_channel_reg;
    logic                          s1_level_reg;
    logic [TIME_BITS-1:0]          s1_now_reg;

    // result stage
    logic                          out_valid_reg;
    logic [dkel_pkg::KEY_W-1:0]    key_code_reg;
    dkel_pkg::status_t             status_reg;
    logic                          any_pend_reg;

    logic                          s1_advance;
    logic                          ch_ok;
    logic [TIME_BITS-1:0]          last_sel;
    logic [TIME_BITS-1:0]          limit;
    logic [TIME_BITS-1:0]          diff;
    logic [1:0]                    en_sel;
    logic                          taken;
    logic [dkel_pkg::KEY_W-1:0]    key_next;
    dkel_pkg::status_t             status_next;
    logic                          any_pend_next;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign cfg.ready  = 1'b1;

    assign rsp.valid       = out_valid_reg;
    assign rsp.key_code    = key_code_reg;
    assign rsp.status      = status_reg;
    assign rsp.any_pending = any_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dkel_pkg::CFG_CHANS; i++)
            begin
                window_reg[i] <= dkel_pkg::WINDOW_RST[i];
            end
            edge_en_reg <= dkel_pkg::EDGE_EN_RST;
            base_reg    <= dkel_pkg::BASE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index) inside
                [dkel_pkg::REG_WINDOW0:dkel_pkg::REG_WINDOW3]:
                    window_reg[cfg.index[1:0]] <= cfg.data[dkel_pkg::WINDOW_W-1:0];
                dkel_pkg::REG_EDGE_EN:
                    edge_en_reg <= cfg.data[dkel_pkg::EDGE_EN_W-1:0];
                dkel_pkg::REG_BASE:
                    base_reg <= cfg.data[dkel_pkg::BASE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // edge path: select the channel, wrap-safe compare against last + window
    always_comb
    begin
        ch_ok    = int'(s1_channel_reg) < NUM_CHANNELS;
        last_sel = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (int'(s1_channel_reg) == c)
            begin
                last_sel = last_reg[c];
            end
        end
        limit  = last_sel + TIME_BITS'(window_reg[s1_channel_reg]);
        diff   = limit - s1_now_reg;
        en_sel = 2'(edge_en_reg >> {s1_channel_reg, 1'b0});
    end

    always_comb
    begin
        key_next    = '0;
        status_next = dkel_pkg::STATUS_IGNORED;
        taken       = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            last_next[c] = last_reg[c];
            pend_next[c] = pend_reg[c];
        end

        if (s1_req_type_reg == dkel_pkg::REQ_EDGE)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (ch_ok && int'(s1_channel_reg) == c && diff[TIME_BITS-1])
                begin
                    last_next[c] = s1_now_reg;
                    if (en_sel[0] && s1_level_reg)
                    begin
                        pend_next[c] = dkel_pkg::CODE_RISE;
                    end
                    else if (en_sel[1] && !s1_level_reg)
                    begin
                        pend_next[c] = dkel_pkg::CODE_FALL;
                    end
                end
            end
            if (ch_ok && diff[TIME_BITS-1])
            begin
                status_next = dkel_pkg::STATUS_OK;
            end
        end
        else
        begin
            status_next = dkel_pkg::STATUS_EMPTY;
            // lowest-numbered pending channel wins
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (!taken && pend_reg[c] != dkel_pkg::CODE_NONE)
                begin
                    taken        = 1'b1;
                    // channels past the base register read a base of 0
                    key_next     = 8'(base_reg >> (8 * c)) + 8'(pend_reg[c]);
                    pend_next[c] = dkel_pkg::CODE_NONE;
                    status_next  = dkel_pkg::STATUS_OK;
                end
            end
        end

        any_pend_next = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            any_pend_next = any_pend_next || (pend_next[c] != dkel_pkg::CODE_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                last_reg[c] <= '0;
                pend_reg[c] <= dkel_pkg::CODE_NONE;
            end
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    last_reg[c] <= last_next[c];
                    pend_reg[c] <= pend_next[c];
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_type_reg <= req.req_type;
            s1_channel_reg  <= req.channel;
            s1_level_reg    <= req.pin_level;
            s1_now_reg      <= TIME_BITS'(req.now_ticks);
        end
        if (s1_advance)
        begin
            key_code_reg <= key_next;
            status_reg   <= status_next;
            any_pend_reg <= any_pend_next;
        end
    end

endmodule

[rtl/dkel_checker.sv]
// Port-level checks for the debounced key event latch, bound to the top level.
// Depends on dkel_pkg and debounced_key_event_latch_top.
module dkel_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [dkel_pkg::KEY_W-1:0]      key_code,
    input dkel_pkg::status_t               status,
    input logic                            any_pending
);

    // an empty read leaves nothing pending and returns no key
    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == dkel_pkg::STATUS_EMPTY |-> key_code == '0 && !any_pending)
        else $error("empty read with key or pending code");

    // debounced edges return no key
    a_ignored_edge: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == dkel_pkg::STATUS_IGNORED |-> key_code == '0)
        else $error("ignored edge carries a key code");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == dkel_pkg::STATUS_OK || status == dkel_pkg::STATUS_IGNORED
                      || status == dkel_pkg::STATUS_EMPTY)
        else $error("undefined status code");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_code) && $stable(status)
                                    && $stable(any_pending))
        else $error("stalled result changed");

endmodule

bind debounced_key_event_latch_top dkel_checker u_dkel_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .key_code    (rsp.key_code),
    .status      (rsp.status),
    .any_pending (rsp.any_pending)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for debounced_key_event_latch_top: directed and random edge and read traffic,
// checked against a cycle-free predictor held in a small scoreboard class.
// Depends on dkel_pkg, the channel interfaces in dkel_if.sv and the top level RTL.
module tb;

    localparam int  RX_HOLD_CYCLES = 64;
    localparam int  IDLE_PCT       = 27;
    localparam int  TIMEOUT_NS     = 1_000_000;
    // indexes past the register list; writes there must be dropped
    localparam logic [dkel_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [dkel_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [dkel_pkg::KEY_W-1:0] key_code;
        dkel_pkg::status_t          status;
        logic                       any_pending;
    } key_result_t;

    class key_latch_scoreboard;
        logic [dkel_pkg::TICKS_W-1:0]   last_accept [dkel_pkg::CFG_CHANS];
        dkel_pkg::pend_t                latched_code [dkel_pkg::CFG_CHANS];
        logic [dkel_pkg::WINDOW_W-1:0]  window [dkel_pkg::CFG_CHANS];
        logic [dkel_pkg::EDGE_EN_W-1:0] edge_en;
        logic [dkel_pkg::BASE_W-1:0]    base_codes;
        key_result_t                    awaited_results [$];
        int mismatches, n_accepted, n_ignored, n_keys, n_empty, n_writes;

        function new();
            for (int c = 0; c < dkel_pkg::CFG_CHANS; c++)
            begin
                last_accept[c]  = '0;
                latched_code[c] = dkel_pkg::CODE_NONE;
                window[c]       = dkel_pkg::WINDOW_RST[c];
            end
            edge_en    = dkel_pkg::EDGE_EN_RST;
            base_codes = dkel_pkg::BASE_RST;
        endfunction

        function void write_register(logic [dkel_pkg::CFG_IDX_W-1:0] idx,
                                     logic [dkel_pkg::CFG_DATA_W-1:0] data);
            n_writes++;
            if (idx >= dkel_pkg::REG_WINDOW0 && idx <= dkel_pkg::REG_WINDOW3)
                window[dkel_pkg::CHAN_W'(idx - dkel_pkg::REG_WINDOW0)] =
                    data[dkel_pkg::WINDOW_W-1:0];
            else if (idx == dkel_pkg::REG_EDGE_EN)
                edge_en = data[dkel_pkg::EDGE_EN_W-1:0];
            else if (idx == dkel_pkg::REG_BASE)
                base_codes = data[dkel_pkg::BASE_W-1:0];
        endfunction

        // predict the result of one accepted request and queue it
        function void note_request(logic rtype, logic [dkel_pkg::CHAN_W-1:0] ch, logic lvl,
                                   logic [dkel_pkg::TICKS_W-1:0] now);
            key_result_t                  r;
            logic [dkel_pkg::TICKS_W-1:0] w, limit, diff;
            logic [1:0]                   en;
            logic                         found;
            r.key_code = '0;
            if (rtype == dkel_pkg::REQ_EDGE)
            begin
                w     = dkel_pkg::TICKS_W'(window[ch]);
                limit = last_accept[ch] + w;
                diff  = limit - now;
                r.status = dkel_pkg::STATUS_IGNORED;
                // negative difference means strictly past the window, modulo wrap
                if (diff[dkel_pkg::TICKS_W-1])
                begin
                    en = edge_en[2*ch +: 2];
                    if (en[0] && lvl)
                        latched_code[ch] = dkel_pkg::CODE_RISE;
                    else if (en[1] && !lvl)
                        latched_code[ch] = dkel_pkg::CODE_FALL;
                    last_accept[ch] = now;
                    r.status = dkel_pkg::STATUS_OK;
                    n_accepted++;
                end
                else
                    n_ignored++;
            end
            else
            begin
                found    = 1'b0;
                r.status = dkel_pkg::STATUS_EMPTY;
                for (int c = 0; c < dkel_pkg::CFG_CHANS; c++)
                begin
                    if (!found && latched_code[c] != dkel_pkg::CODE_NONE)
                    begin
                        found      = 1'b1;
                        r.key_code = base_codes[8*c +: 8]
                                     + dkel_pkg::KEY_W'(latched_code[c]);
                        r.status   = dkel_pkg::STATUS_OK;
                        latched_code[c] = dkel_pkg::CODE_NONE;
                    end
                end
                if (found)
                    n_keys++;
                else
                    n_empty++;
            end
            r.any_pending = 1'b0;
            for (int c = 0; c < dkel_pkg::CFG_CHANS; c++)
                if (latched_code[c] != dkel_pkg::CODE_NONE)
                    r.any_pending = 1'b1;
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [dkel_pkg::KEY_W-1:0] key, dkel_pkg::status_t st,
                                   logic anyp);
            key_result_t e;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result key_code=%0d status=%0d any_pending=%0b",
                         $time, key, st, anyp);
                mismatches++;
            end
            else
            begin
                e = awaited_results.pop_front();
                if (key !== e.key_code)
                begin
                    $display("%0t: key_code expected %0d got %0d", $time, e.key_code, key);
                    mismatches++;
                end
                if (st !== e.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, e.status, st);
                    mismatches++;
                end
                if (anyp !== e.any_pending)
                begin
                    $display("%0t: any_pending expected %0b got %0b", $time, e.any_pending, anyp);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_idle_en;
    bit   rx_idle_en;
    bit   rx_hold_req;

    key_latch_scoreboard sb;

    dkel_req_if req_ch();
    dkel_rsp_if rsp_ch();
    dkel_cfg_if cfg_ch();

    debounced_key_event_latch_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random backpressure, plus a long hold when asked
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.key_code, rsp_ch.status, rsp_ch.any_pending);

    task automatic send_item(logic rtype, logic [dkel_pkg::CHAN_W-1:0] ch, logic lvl,
                             logic [dkel_pkg::TICKS_W-1:0] now);
        @(negedge clk);
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rtype;
        req_ch.channel   <= ch;
        req_ch.pin_level <= lvl;
        req_ch.now_ticks <= now;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(rtype, ch, lvl, now);
    endtask

    task automatic write_reg(logic [dkel_pkg::CFG_IDX_W-1:0] idx,
                             logic [dkel_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop offering, let every result come back, then cover the pipeline depth
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_windows(logic [dkel_pkg::WINDOW_W-1:0] lo,
                               logic [dkel_pkg::WINDOW_W-1:0] hi);
        for (int c = 0; c < dkel_pkg::CFG_CHANS; c++)
            write_reg(dkel_pkg::CFG_IDX_W'(dkel_pkg::REG_WINDOW0 + c),
                      $urandom_range(lo, hi));
    endtask

    // reads mixed with edges; most edges land right at the debounce boundary or at the wrap boundary
    task automatic run_random(int count);
        logic [dkel_pkg::CHAN_W-1:0]  ch;
        logic [dkel_pkg::TICKS_W-1:0] now, limit, w;
        int                           pick;
        repeat (count)
        begin
            pick  = $urandom_range(0, 99);
            ch    = dkel_pkg::CHAN_W'($urandom_range(0, dkel_pkg::CFG_CHANS - 1));
            w     = dkel_pkg::TICKS_W'(sb.window[ch]);
            limit = sb.last_accept[ch] + w;
            if (pick < 35)
                now = $urandom;
            else if (pick < 70)
                now = limit + $urandom_range(0, 6) - 3;
            else if (pick < 82)
                now = sb.last_accept[ch] + $urandom_range(0, 2 * w + 8);
            else if (pick < 90)
                now = limit + 32'h8000_0000 + $urandom_range(0, 4) - 2;
            else
                now = $urandom;
            send_item(pick < 35 ? dkel_pkg::REQ_READ : dkel_pkg::REQ_EDGE, ch,
                      1'($urandom_range(0, 1)), now);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n            = 1'b0;
        tx_idle_en       = 1'b1;
        rx_idle_en       = 1'b1;
        rx_hold_req      = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = dkel_pkg::REQ_EDGE;
        req_ch.channel   = '0;
        req_ch.pin_level = 1'b0;
        req_ch.now_ticks = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = dkel_pkg::REG_WINDOW0;
        cfg_ch.data      = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: ch0/ch3 rising only with 1200 ticks, ch1/ch2 both with 1 tick
        send_item(dkel_pkg::REQ_READ, 2'd0, 1'b0, 32'd0);
        send_item(dkel_pkg::REQ_EDGE, 2'd0, 1'b1, 32'd1200);
        send_item(dkel_pkg::REQ_EDGE, 2'd0, 1'b1, 32'd1201);
        send_item(dkel_pkg::REQ_EDGE, 2'd0, 1'b0, 32'd5000);
        send_item(dkel_pkg::REQ_EDGE, 2'd1, 1'b0, 32'd2);
        send_item(dkel_pkg::REQ_EDGE, 2'd1, 1'b1, 32'd3);
        send_item(dkel_pkg::REQ_EDGE, 2'd3, 1'b1, 32'h8000_04AF);
        send_item(dkel_pkg::REQ_EDGE, 2'd3, 1'b1, 32'h8000_04B1);
        send_item(dkel_pkg::REQ_EDGE, 2'd2, 1'b1, 32'h8000_0001);
        send_item(dkel_pkg::REQ_EDGE, 2'd2, 1'b0, 32'hFFFF_FFFF);
        send_item(dkel_pkg::REQ_EDGE, 2'd3, 1'b0, 32'd0);
        repeat (5) send_item(dkel_pkg::REQ_READ, 2'd3, 1'b1, 32'hFFFF_FFFF);
        send_item(dkel_pkg::REQ_EDGE, 2'd1, 1'b1, 32'hFFFF_FFFF);
        wait_idle();

        // zero windows, every edge kind enabled, base bytes that wrap on add
        set_windows(16'd0, 16'd0);
        write_reg(dkel_pkg::REG_EDGE_EN, 32'hFF);
        write_reg(dkel_pkg::REG_BASE, 32'hFFFF_FFFF);
        run_random(120);
        rx_hold_req = 1'b1;
        tx_idle_en  = 1'b0;
        run_random(30);
        tx_idle_en  = 1'b1;
        wait_idle();
        run_random(40);
        wait_idle();

        set_windows(16'hFFFF, 16'hFFFF);
        write_reg(dkel_pkg::REG_EDGE_EN, 32'h00);
        write_reg(dkel_pkg::REG_BASE, 32'h0);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        run_random(120);
        wait_idle();

        // back-to-back stretch with no idling on either side
        set_windows(16'd0, 16'd20);
        write_reg(dkel_pkg::REG_EDGE_EN, $urandom_range(0, 255));
        write_reg(dkel_pkg::REG_BASE, $urandom);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(150);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        wait_idle();

        repeat (3)
        begin
            if ($urandom_range(0, 3) == 0)
                set_windows(16'd0, 16'hFFFF);
            else
                set_windows(16'd0, 16'd40);
            write_reg(dkel_pkg::REG_EDGE_EN, $urandom_range(0, 255));
            write_reg(dkel_pkg::REG_BASE, $urandom);
            run_random(130);
            wait_idle();
        end

        if (sb.awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.awaited_results.size());
            sb.mismatches++;
        end
        $display("Covered %0d edges (%0d taken, %0d debounced) and %0d reads (%0d keys, %0d empty),",
                 sb.n_accepted + sb.n_ignored, sb.n_accepted, sb.n_ignored,
                 sb.n_keys + sb.n_empty, sb.n_keys, sb.n_empty);
        $display("across %0d register writes; %0d mismatches.", sb.n_writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
